[design/ctgs_pkg.sv]
// Shared types and constants of the co-simulation time grant scheduler.
`default_nettype none
package ctgs_pkg;
	localparam int unsigned TIME_W = 64;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
	localparam logic [TIME_W-1:0] ONE_SECOND_NS = 64'd1000000000;

	// Input action codes.
	localparam logic [2:0] ACT_REGISTER = 3'd0;
	localparam logic [2:0] ACT_REQUEST  = 3'd1;
	localparam logic [2:0] ACT_DEPART   = 3'd2;
	localparam logic [2:0] ACT_PUBLISH  = 3'd3;
	localparam logic [2:0] ACT_DELTA    = 3'd4;

	// Result kind codes.
	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_GRANT  = 2'd1;
	localparam logic [1:0] KIND_FINISH = 2'd2;
	localparam logic [1:0] KIND_ERROR  = 2'd3;

	// Datapath operations issued by the controller.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_DECODE,    // load the transaction into the datapath registers
		OP_APPLY,     // apply register, publish, delta or report updates
		OP_MIN,       // fold the actionable time of the entry at the cursor
		OP_GRANT,     // grant or prepare fast forward for the entry at the cursor
		OP_DIV_STEP,  // one quotient bit of the fast forward division
		OP_FF_MUL,    // one multiply-accumulate step of the fast forward
		OP_EMIT,      // load a result into the output register
		OP_CUR_NEXT,  // advance the cursor
		OP_CUR_CLR    // clear the cursor
	} dp_op_t;

	typedef enum logic [2:0] {
		DEC_ERROR,
		DEC_SILENT,
		DEC_START,
		DEC_GRANT,
		DEC_FINISH
	} dec_t;

	typedef struct packed {
		dp_op_t     op;
		logic [1:0] kind;
		logic       last;
	} dp_cmd_t;

	typedef struct packed {
		dec_t verdict;   // what the decoded transaction calls for
		logic cur_last;  // cursor at the last active entry
		logic grant_hit; // entry at the cursor is granted
		logic ff_need;   // entry at the cursor needs fast forward
		logic div_done;  // division finished
		logic mul_done;  // multiply-accumulate finished
		logic any_grant; // some entry after the cursor will still be granted
		logic out_busy;  // output register holds an untaken result
	} dp_sts_t;
endpackage
`default_nettype wire

[design/ctgs_datapath.sv]
// Datapath of the time grant scheduler: simulator table, divider, multiplier and result register.
`default_nettype none
module ctgs_datapath #(
	parameter int unsigned MAX_SIMS = 16
) (
	input  wire  logic                clk,
	input  wire  logic                arst_n,
	input  wire  ctgs_pkg::dp_cmd_t   cmd,
	output       ctgs_pkg::dp_sts_t   sts,
	input  wire  logic                cfg_valid,
	input  wire  logic [4:0]          cfg_data,
	input  wire  logic [2:0]          action,
	input  wire  logic [3:0]          sim_index,
	input  wire  logic [63:0]         time_value,
	input  wire  logic [15:0]         subscriber_mask,
	output       logic                out_valid,
	input  wire  logic                out_ready,
	output       logic [1:0]          kind,
	output       logic [3:0]          target_index,
	output       logic [63:0]         granted_time,
	output       logic                last_of_run
);
	localparam int unsigned IW = (MAX_SIMS > 1) ? $clog2(MAX_SIMS) : 1;
	localparam int unsigned CW = $clog2(MAX_SIMS + 1);
	localparam int unsigned TW = ctgs_pkg::TIME_W;

	// Simulator table.
	logic [TW-1:0] req_q   [MAX_SIMS];
	logic [TW-1:0] delta_q [MAX_SIMS];
	logic [TW-1:0] last_q  [MAX_SIMS];
	logic [MAX_SIMS-1:0] busy_q, pend_q, gone_q, reg_q;
	logic [CW-1:0] reg_cnt_q, busy_cnt_q, n_q;
	logic [TW-1:0] gtime_q;
	logic finished_q;

	// Transaction registers.
	logic [2:0] act_q;
	logic [3:0] idx_q;
	logic [TW-1:0] tv_q;
	logic [15:0] mask_q;
	ctgs_pkg::dec_t verdict_q;

	// Walk and arithmetic registers.
	logic [IW-1:0] cur_q;
	logic [IW-1:0] hit_last_q;
	logic [TW-1:0] min_q;
	logic [TW-1:0] rem_q, quo_q, dvs_q, acc_q;
	logic [6:0] bit_q;

	// Configured count, clamped.
	logic [CW-1:0] n_cfg;
	always_comb begin
		if (cfg_data == 5'd0) begin
			n_cfg = CW'(1);
		end else if (32'(cfg_data) > MAX_SIMS) begin
			n_cfg = CW'(MAX_SIMS);
		end else begin
			n_cfg = CW'(cfg_data);
		end
	end

	// Actionable time of the entry at the cursor.
	logic [TW:0] sum_c;
	logic [TW-1:0] act_c;
	always_comb begin
		sum_c = {1'b0, last_q[cur_q]} + {1'b0, delta_q[cur_q]};
		if (pend_q[cur_q]) begin
			act_c = sum_c[TW] ? ctgs_pkg::TIME_MAX : sum_c[TW-1:0];
		end else begin
			act_c = req_q[cur_q];
		end
	end

	// Decode of the transaction on the input port; the verdict is registered
	// together with the payload when the transaction is accepted.
	logic [IW-1:0] s_c;
	logic [IW-1:0] d_s_c;
	logic idx_ok;
	logic [MAX_SIMS-1:0] gone_after;
	ctgs_pkg::dec_t dec_c;
	always_comb begin
		s_c = IW'(idx_q);
		d_s_c = IW'(sim_index);
		idx_ok = {{(32-CW){1'b0}}, n_q} > 32'(sim_index);
		gone_after = gone_q;
		gone_after[d_s_c] = 1'b1;
		dec_c = ctgs_pkg::DEC_SILENT;
		if (finished_q || action > ctgs_pkg::ACT_DELTA || !idx_ok) begin
			dec_c = ctgs_pkg::DEC_ERROR;
		end else if (action == ctgs_pkg::ACT_REGISTER) begin
			if (reg_q[d_s_c]) begin
				dec_c = ctgs_pkg::DEC_ERROR;
			end else if (reg_cnt_q + CW'(1) == n_q) begin
				dec_c = ctgs_pkg::DEC_START;
			end
		end else if (!reg_q[d_s_c]) begin
			dec_c = ctgs_pkg::DEC_ERROR;
		end else if (action == ctgs_pkg::ACT_PUBLISH || action == ctgs_pkg::ACT_DELTA) begin
			dec_c = ctgs_pkg::DEC_SILENT;
		end else if (!busy_q[d_s_c]) begin
			dec_c = ctgs_pkg::DEC_ERROR;
		end else if (action == ctgs_pkg::ACT_DEPART &&
				CW'($countones(gone_after)) == n_q) begin
			dec_c = ctgs_pkg::DEC_FINISH;
		end else if (busy_cnt_q <= CW'(1)) begin
			dec_c = ctgs_pkg::DEC_GRANT;
		end
	end

	// Status to the controller.
	always_comb begin
		sts.verdict   = verdict_q;
		sts.cur_last  = ({{(32-IW){1'b0}}, cur_q} + 32'd1) >= {{(32-CW){1'b0}}, n_q};
		sts.grant_hit = act_c == gtime_q;
		sts.ff_need   = delta_q[cur_q] != '0 && gtime_q >= last_q[cur_q];
		sts.div_done  = bit_q == 7'd0;
		sts.mul_done  = quo_q == '0;
		sts.any_grant = cur_q < hit_last_q;
		sts.out_busy  = out_valid;
	end

	// Shift-subtract division step.
	logic [TW:0] trial_c;
	always_comb begin
		trial_c = {rem_q, quo_q[TW-1]} - {1'b0, dvs_q};
	end

	// Control state of the table and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			pend_q <= '0;
			gone_q <= '0;
			reg_q <= '0;
			reg_cnt_q <= '0;
			busy_cnt_q <= '0;
			n_q <= CW'(1);
			finished_q <= 1'b0;
			gtime_q <= '0;
			verdict_q <= ctgs_pkg::DEC_SILENT;
			cur_q <= '0;
			hit_last_q <= '0;
			bit_q <= '0;
			out_valid <= 1'b0;
			for (int i = 0; i < MAX_SIMS; i++) begin
				req_q[i] <= '0;
				last_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && reg_cnt_q == '0) begin
				n_q <= n_cfg;
			end
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			case (cmd.op)
				ctgs_pkg::OP_DECODE: begin
					verdict_q <= dec_c;
					if (dec_c == ctgs_pkg::DEC_FINISH) begin
						finished_q <= 1'b1;
					end
				end
				ctgs_pkg::OP_APPLY: begin
					if (verdict_q != ctgs_pkg::DEC_ERROR &&
							verdict_q != ctgs_pkg::DEC_FINISH) begin
						case (act_q)
							ctgs_pkg::ACT_REGISTER: begin
								reg_q[s_c] <= 1'b1;
								req_q[s_c] <= '0;
								last_q[s_c] <= '0;
								pend_q[s_c] <= 1'b0;
								reg_cnt_q <= reg_cnt_q + CW'(1);
								if (verdict_q == ctgs_pkg::DEC_START) begin
									for (int i = 0; i < MAX_SIMS; i++) begin
										busy_q[i] <= 32'(i) < {{(32-CW){1'b0}}, n_q};
									end
									busy_cnt_q <= n_q;
								end else begin
									busy_q[s_c] <= 1'b0;
								end
							end
							ctgs_pkg::ACT_PUBLISH: begin
								for (int i = 0; i < MAX_SIMS; i++) begin
									if (i < 16 && 32'(i) < {{(32-CW){1'b0}}, n_q} &&
											mask_q[i % 16] && reg_q[i] && !gone_q[i]) begin
										pend_q[i] <= 1'b1;
									end
								end
							end
							ctgs_pkg::ACT_REQUEST, ctgs_pkg::ACT_DEPART: begin
								if (act_q == ctgs_pkg::ACT_DEPART) begin
									gone_q[s_c] <= 1'b1;
									req_q[s_c] <= ctgs_pkg::TIME_MAX;
								end else begin
									req_q[s_c] <= tv_q;
								end
								last_q[s_c] <= gtime_q;
								busy_q[s_c] <= 1'b0;
								if (busy_cnt_q != '0) begin
									busy_cnt_q <= busy_cnt_q - CW'(1);
								end
							end
							default: begin
							end
						endcase
					end
					cur_q <= '0;
					gtime_q <= (verdict_q == ctgs_pkg::DEC_GRANT) ? ctgs_pkg::TIME_MAX
						: gtime_q;
				end
				ctgs_pkg::OP_MIN: begin
					// Track the minimum and the last entry that reaches it.
					if (act_c < gtime_q) begin
						gtime_q <= act_c;
					end
					if (act_c <= gtime_q) begin
						hit_last_q <= cur_q;
					end
				end
				ctgs_pkg::OP_GRANT: begin
					if (act_c == gtime_q) begin
						busy_q[cur_q] <= 1'b1;
						pend_q[cur_q] <= 1'b0;
						busy_cnt_q <= busy_cnt_q + CW'(1);
					end else begin
						bit_q <= 7'(TW);
					end
				end
				ctgs_pkg::OP_DIV_STEP: begin
					bit_q <= bit_q - 7'd1;
				end
				ctgs_pkg::OP_FF_MUL: begin
					if (quo_q == '0) begin
						last_q[cur_q] <= acc_q;
					end
				end
				ctgs_pkg::OP_EMIT: begin
					out_valid <= 1'b1;
				end
				ctgs_pkg::OP_CUR_NEXT: begin
					cur_q <= cur_q + IW'(1);
				end
				ctgs_pkg::OP_CUR_CLR: begin
					cur_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Step delta store, payload, arithmetic and result registers; no reset needed.
	always_ff @(posedge clk) begin
		case (cmd.op)
			ctgs_pkg::OP_DECODE: begin
				act_q <= action;
				idx_q <= sim_index;
				tv_q <= time_value;
				mask_q <= subscriber_mask;
			end
			ctgs_pkg::OP_APPLY: begin
				if (verdict_q != ctgs_pkg::DEC_ERROR && verdict_q != ctgs_pkg::DEC_FINISH) begin
					if (act_q == ctgs_pkg::ACT_REGISTER) begin
						delta_q[s_c] <= (tv_q == '0) ? ctgs_pkg::ONE_SECOND_NS : tv_q;
					end else if (act_q == ctgs_pkg::ACT_DELTA) begin
						delta_q[s_c] <= tv_q;
					end
				end
			end
			ctgs_pkg::OP_GRANT: begin
				// Set up (g - last) / delta.
				rem_q <= '0;
				quo_q <= gtime_q - last_q[cur_q];
				dvs_q <= delta_q[cur_q];
				acc_q <= last_q[cur_q];
			end
			ctgs_pkg::OP_DIV_STEP: begin
				if (!trial_c[TW]) begin
					rem_q <= trial_c[TW-1:0];
					quo_q <= {quo_q[TW-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[TW-2:0], quo_q[TW-1]};
					quo_q <= {quo_q[TW-2:0], 1'b0};
				end
			end
			ctgs_pkg::OP_FF_MUL: begin
				// Shift-add multiply: acc += delta * quotient, one bit a step.
				if (quo_q[0]) begin
					acc_q <= acc_q + dvs_q;
				end
				quo_q <= {1'b0, quo_q[TW-1:1]};
				dvs_q <= {dvs_q[TW-2:0], 1'b0};
			end
			ctgs_pkg::OP_EMIT: begin
				kind <= cmd.kind;
				last_of_run <= cmd.last;
				if (cmd.kind == ctgs_pkg::KIND_ERROR) begin
					target_index <= idx_q;
					granted_time <= '0;
				end else begin
					target_index <= 4'(cur_q);
					granted_time <= (cmd.kind == ctgs_pkg::KIND_START) ? '0 : gtime_q;
				end
			end
			default: begin
			end
		endcase
	end
endmodule
`default_nettype wire

[design/ctgs_ctrl.sv]
// Controller state machine of the time grant scheduler.
`default_nettype none
module ctgs_ctrl (
	input  wire  logic              clk,
	input  wire  logic              arst_n,
	input  wire  logic              in_valid,
	output       logic              in_ready,
	output       ctgs_pkg::dp_cmd_t cmd,
	input  wire  ctgs_pkg::dp_sts_t sts
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DECODE, ST_APPLY, ST_ERR, ST_LIST, ST_MIN, ST_REWIND, ST_GRANT,
		ST_DIV, ST_MUL, ST_GEMIT, ST_NEXT
	} state_t;

	state_t state_q;
	logic [1:0] list_kind_q;
	logic pend_emit_q;

	// Next-step command decode.
	always_comb begin
		cmd.op = ctgs_pkg::OP_NONE;
		cmd.kind = list_kind_q;
		cmd.last = sts.cur_last;
		in_ready = state_q == ST_IDLE;
		case (state_q)
			ST_IDLE:   cmd.op = in_valid ? ctgs_pkg::OP_DECODE : ctgs_pkg::OP_NONE;
			ST_DECODE: cmd.op = ctgs_pkg::OP_APPLY;
			ST_ERR: begin
				cmd.kind = ctgs_pkg::KIND_ERROR;
				cmd.last = 1'b1;
				cmd.op = sts.out_busy ? ctgs_pkg::OP_NONE : ctgs_pkg::OP_EMIT;
			end
			ST_LIST: begin
				cmd.op = sts.out_busy ? ctgs_pkg::OP_NONE : ctgs_pkg::OP_EMIT;
			end
			ST_MIN:    cmd.op = ctgs_pkg::OP_MIN;
			ST_REWIND: cmd.op = ctgs_pkg::OP_CUR_CLR;
			ST_GRANT:  cmd.op = ctgs_pkg::OP_GRANT;
			ST_DIV:    cmd.op = sts.div_done ? ctgs_pkg::OP_NONE : ctgs_pkg::OP_DIV_STEP;
			ST_MUL:    cmd.op = ctgs_pkg::OP_FF_MUL;
			ST_GEMIT: begin
				cmd.kind = ctgs_pkg::KIND_GRANT;
				cmd.last = !sts.any_grant;
				cmd.op = sts.out_busy ? ctgs_pkg::OP_NONE : ctgs_pkg::OP_EMIT;
			end
			ST_NEXT:  cmd.op = ctgs_pkg::OP_CUR_NEXT;
			default:  cmd.op = ctgs_pkg::OP_NONE;
		endcase
	end

	// Sequencer. A grant walks the table once for the minimum, rewinds the
	// cursor, then walks it again to grant or fast forward each entry that calls
	// for it; pend_emit_q tells the second walk from the first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			list_kind_q <= ctgs_pkg::KIND_START;
			pend_emit_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_DECODE;
				ST_DECODE: begin
					case (sts.verdict)
						ctgs_pkg::DEC_ERROR: state_q <= ST_ERR;
						ctgs_pkg::DEC_START: begin
							list_kind_q <= ctgs_pkg::KIND_START;
							state_q <= ST_LIST;
						end
						ctgs_pkg::DEC_FINISH: begin
							list_kind_q <= ctgs_pkg::KIND_FINISH;
							state_q <= ST_LIST;
						end
						ctgs_pkg::DEC_GRANT: begin
							list_kind_q <= ctgs_pkg::KIND_GRANT;
							pend_emit_q <= 1'b0;
							state_q <= ST_MIN;
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_ERR: if (!sts.out_busy) state_q <= ST_IDLE;
				ST_LIST: begin
					if (!sts.out_busy) begin
						state_q <= sts.cur_last ? ST_IDLE : ST_NEXT;
						pend_emit_q <= 1'b0;
					end
				end
				ST_MIN: state_q <= sts.cur_last ? ST_REWIND : ST_NEXT;
				ST_REWIND: begin
					pend_emit_q <= 1'b1;
					state_q <= ST_GRANT;
				end
				ST_GRANT: begin
					if (sts.grant_hit) begin
						state_q <= ST_GEMIT;
					end else if (sts.ff_need) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= sts.cur_last ? ST_IDLE : ST_NEXT;
					end
				end
				ST_DIV: if (sts.div_done) state_q <= ST_MUL;
				ST_MUL: if (sts.mul_done) state_q <= sts.cur_last ? ST_IDLE : ST_NEXT;
				ST_GEMIT: if (!sts.out_busy) state_q <= sts.cur_last ? ST_IDLE : ST_NEXT;
				ST_NEXT: begin
					if (list_kind_q != ctgs_pkg::KIND_GRANT) begin
						state_q <= ST_LIST;
					end else if (pend_emit_q) begin
						state_q <= ST_GRANT;
					end else begin
						state_q <= ST_MIN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[design/cosim_time_grant_scheduler_core.sv]
// Top level of the co-simulation time grant scheduler.
// One transaction is handled at a time. A register, publish, delta or silent
// report passes through decode and apply; an error then emits one error result
// once the output is free; a start or finish list emits one result per
// simulator. A grant walks the table twice, once for the minimum and then,
// per entry, a grant, a fast forward or neither, where every fast forward runs
// a 64-step serial divider and a shift-add multiply of up to 65 steps. Every
// result also waits for the output to be taken. Results leave through a
// registered valid/ready port.
`default_nettype none
module cosim_time_grant_scheduler_core #(
	parameter int unsigned MAX_SIMS = 16
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        cfg_valid,
	output       logic        cfg_ready,
	input  wire  logic [4:0]  cfg_data,
	input  wire  logic        in_valid,
	output       logic        in_ready,
	input  wire  logic [2:0]  action,
	input  wire  logic [3:0]  sim_index,
	input  wire  logic [63:0] time_value,
	input  wire  logic [15:0] subscriber_mask,
	output       logic        out_valid,
	input  wire  logic        out_ready,
	output       logic [1:0]  kind,
	output       logic [3:0]  target_index,
	output       logic [63:0] granted_time,
	output       logic        last_of_run
);
	ctgs_pkg::dp_cmd_t cmd;
	ctgs_pkg::dp_sts_t sts;

	assign cfg_ready = 1'b1;

	ctgs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .sts(sts)
	);

	ctgs_datapath #(.MAX_SIMS(MAX_SIMS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.action(action), .sim_index(sim_index), .time_value(time_value),
		.subscriber_mask(subscriber_mask),
		.out_valid(out_valid), .out_ready(out_ready), .kind(kind),
		.target_index(target_index), .granted_time(granted_time),
		.last_of_run(last_of_run)
	);
endmodule
`default_nettype wire
